### src/rpdp_pkg.sv
// ----------------------------------------------------------------------------
// rpdp_pkg
// Shared types, codes, tables and rounding helpers for the point plotter.
// ----------------------------------------------------------------------------
package rpdp_pkg;

  localparam int SCREEN_COLS_DEF = 128;
  localparam int SCREEN_ROWS_DEF = 64;
  localparam int DIV_STEPS       = 25;

  typedef enum logic [1:0] {
    FUNC_PLOT  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam logic [2:0] CFG_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_HEIGHT   = 3'd1;
  localparam logic [2:0] CFG_FOCAL    = 3'd2;
  localparam logic [2:0] CFG_ASPECT_X = 3'd3;
  localparam logic [2:0] CFG_ASPECT_Y = 3'd4;
  localparam logic [2:0] CFG_VIEW     = 3'd5;
  localparam logic [2:0] CFG_BG       = 3'd6;

  typedef enum logic [4:0] {
    OP_NOP, OP_CASB, OP_SASB, OP_M00, OP_M01A, OP_M01B, OP_M02A, OP_M02B,
    OP_M10, OP_M11A, OP_M11B, OP_M12A, OP_M12B, OP_M21, OP_M22,
    OP_X0, OP_X1, OP_X2, OP_Y0, OP_Y1, OP_Y2, OP_Z0, OP_Z1, OP_Z2,
    OP_FI, OP_FIAX, OP_COL, OP_FIAY, OP_ROW, OP_CELL
  } op_t;

  typedef enum logic [2:0] {
    KIND_NONE, KIND_DROP, KIND_BADIDX, KIND_PLOT, KIND_CELL
  } kind_t;

  typedef enum logic [3:0] {
    ST_SWEEP, ST_IDLE, ST_DISPATCH, ST_CALC, ST_ZCHK, ST_DIV, ST_PROJ,
    ST_CCHK, ST_UPDATE, ST_DROP, ST_BADIDX, ST_CELLRD, ST_CELLOUT
  } state_t;

  typedef struct packed {
    op_t   op;
    kind_t kind;
    logic  load;
    logic  div_start;
    logic  div_step;
    logic  mem_rd;
    logic  out_load;
    logic  sweep;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  idx_bad;
    logic  z_low;
    logic  div_done;
    logic  cell_bad;
    logic  out_free;
    logic  sweep_last;
  } sts_t;

  function automatic logic [14:0] quarter_sine(input logic [6:0] k);
    logic [14:0] v;
    case (k)
      7'd0: v = 15'd0;      7'd1: v = 15'd402;    7'd2: v = 15'd804;
      7'd3: v = 15'd1205;   7'd4: v = 15'd1606;   7'd5: v = 15'd2006;
      7'd6: v = 15'd2404;   7'd7: v = 15'd2801;   7'd8: v = 15'd3196;
      7'd9: v = 15'd3590;   7'd10: v = 15'd3981;  7'd11: v = 15'd4370;
      7'd12: v = 15'd4756;  7'd13: v = 15'd5139;  7'd14: v = 15'd5520;
      7'd15: v = 15'd5897;  7'd16: v = 15'd6270;  7'd17: v = 15'd6639;
      7'd18: v = 15'd7005;  7'd19: v = 15'd7366;  7'd20: v = 15'd7723;
      7'd21: v = 15'd8076;  7'd22: v = 15'd8423;  7'd23: v = 15'd8765;
      7'd24: v = 15'd9102;  7'd25: v = 15'd9434;  7'd26: v = 15'd9760;
      7'd27: v = 15'd10080; 7'd28: v = 15'd10394; 7'd29: v = 15'd10702;
      7'd30: v = 15'd11003; 7'd31: v = 15'd11297; 7'd32: v = 15'd11585;
      7'd33: v = 15'd11866; 7'd34: v = 15'd12140; 7'd35: v = 15'd12406;
      7'd36: v = 15'd12665; 7'd37: v = 15'd12916; 7'd38: v = 15'd13160;
      7'd39: v = 15'd13395; 7'd40: v = 15'd13623; 7'd41: v = 15'd13842;
      7'd42: v = 15'd14053; 7'd43: v = 15'd14256; 7'd44: v = 15'd14449;
      7'd45: v = 15'd14635; 7'd46: v = 15'd14811; 7'd47: v = 15'd14978;
      7'd48: v = 15'd15137; 7'd49: v = 15'd15286; 7'd50: v = 15'd15426;
      7'd51: v = 15'd15557; 7'd52: v = 15'd15679; 7'd53: v = 15'd15791;
      7'd54: v = 15'd15893; 7'd55: v = 15'd15986; 7'd56: v = 15'd16069;
      7'd57: v = 15'd16143; 7'd58: v = 15'd16207; 7'd59: v = 15'd16261;
      7'd60: v = 15'd16305; 7'd61: v = 15'd16340; 7'd62: v = 15'd16364;
      7'd63: v = 15'd16379; 7'd64: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // Sine in signed Q1.14 from phase bits 15..8.
  function automatic logic signed [15:0] table_sin(input logic [15:0] ph);
    logic [1:0]         q;
    logic [5:0]         j;
    logic [6:0]         k;
    logic signed [15:0] m;
    q = ph[15:14];
    j = ph[13:8];
    k = q[0] ? 7'(7'd64 - {1'b0, j}) : {1'b0, j};
    m = $signed({1'b0, quarter_sine(k)});
    return q[1] ? -m : m;
  endfunction

  // Round to nearest, halves away from zero.
  function automatic logic signed [63:0] rnd14(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v >= 0) r = (v + 64'sd8192) >>> 14;
    else        r = -((-v + 64'sd8192) >>> 14);
    return r;
  endfunction

  function automatic logic signed [63:0] rnd32(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v >= 0) r = (v + 64'sd2147483648) >>> 32;
    else        r = -((-v + 64'sd2147483648) >>> 32);
    return r;
  endfunction

endpackage

### src/rpdp_ctrl.sv
// ----------------------------------------------------------------------------
// rpdp_ctrl
// Sequencer: steps the shared multiplier ops, the divider and the store access.
// ----------------------------------------------------------------------------
module rpdp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output rpdp_pkg::cmd_t cmd,
  input  rpdp_pkg::sts_t sts
);
  import rpdp_pkg::*;

  state_t state, state_next;
  op_t    op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      op    <= OP_NOP;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = OP_NOP;
    cmd.kind   = KIND_NONE;
    s_tready   = 1'b0;
    case (state)
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.func)
          FUNC_PLOT: begin
            state_next = ST_CALC;
            op_next    = OP_CASB;
          end
          FUNC_NONE: state_next = ST_IDLE;
          default:   state_next = sts.idx_bad ? ST_BADIDX : ST_CELLRD;
        endcase
      end
      ST_CALC: begin
        cmd.op  = op;
        op_next = op_t'(op + 5'd1);
        if (op == OP_Z2) state_next = ST_ZCHK;
      end
      ST_ZCHK: begin
        if (sts.z_low) begin
          state_next = ST_DROP;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = ST_PROJ;
          op_next    = OP_FI;
        end
      end
      ST_PROJ: begin
        cmd.op  = op;
        op_next = op_t'(op + 5'd1);
        if (op == OP_CELL) state_next = ST_CCHK;
      end
      ST_CCHK: begin
        if (sts.cell_bad) begin
          state_next = ST_DROP;
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.kind     = KIND_PLOT;
          state_next   = ST_IDLE;
        end
      end
      ST_DROP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.kind     = KIND_DROP;
          state_next   = ST_IDLE;
        end
      end
      ST_BADIDX: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.kind     = KIND_BADIDX;
          state_next   = ST_IDLE;
        end
      end
      ST_CELLRD: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_CELLOUT;
      end
      ST_CELLOUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.kind     = KIND_CELL;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### src/rpdp_datapath.sv
// ----------------------------------------------------------------------------
// rpdp_datapath
// Shared multiplier, bit-serial divider, glyph and depth stores, result register.
// ----------------------------------------------------------------------------
module rpdp_datapath #(
  parameter int SCREEN_COLS = rpdp_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = rpdp_pkg::SCREEN_ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  rpdp_pkg::cmd_t cmd,
  output rpdp_pkg::sts_t sts,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [11:0]    cfg_data,
  input  logic [119:0]   s_tdata,
  input  logic [1:0]     s_tuser,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [39:0]    m_tdata,
  output logic [1:0]     m_tuser
);
  import rpdp_pkg::*;

  localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW         = $clog2(CELL_COUNT);

  // configuration
  logic [7:0]  scr_w;
  logic [6:0]  scr_h;
  logic [11:0] focal;
  logic [7:0]  asp_x;
  logic [7:0]  asp_y;
  logic [9:0]  view_d;
  logic [7:0]  bg_glyph;

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w    <= 8'd80;
      scr_h    <= 7'd24;
      focal    <= 12'd384;
      asp_x    <= 8'd32;
      asp_y    <= 8'd16;
      view_d   <= 10'd60;
      bg_glyph <= 8'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:    scr_w    <= cfg_data[7:0];
        CFG_HEIGHT:   scr_h    <= cfg_data[6:0];
        CFG_FOCAL:    focal    <= cfg_data;
        CFG_ASPECT_X: asp_x    <= cfg_data[7:0];
        CFG_ASPECT_Y: asp_y    <= cfg_data[7:0];
        CFG_VIEW:     view_d   <= cfg_data[9:0];
        CFG_BG:       bg_glyph <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [7:0]  w_eff;
  logic [6:0]  h_eff;
  logic [14:0] wh;

  always_comb begin
    if (scr_w == 8'd0)                 w_eff = 8'd1;
    else if (32'(scr_w) > SCREEN_COLS) w_eff = 8'(SCREEN_COLS);
    else                               w_eff = scr_w;
    if (scr_h == 7'd0)                 h_eff = 7'd1;
    else if (32'(scr_h) > SCREEN_ROWS) h_eff = 7'(SCREEN_ROWS);
    else                               h_eff = scr_h;
  end
  assign wh = 15'(w_eff * h_eff);

  // item registers
  func_t              func;
  logic signed [15:0] px, py, pz;
  logic [7:0]         glyph_in;
  logic [12:0]        idx;
  logic signed [15:0] sa, ca, sb, cb, sc, cc;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func     <= func_t'(s_tuser);
      px       <= $signed(s_tdata[15:0]);
      py       <= $signed(s_tdata[31:16]);
      pz       <= $signed(s_tdata[47:32]);
      sa       <= table_sin(s_tdata[63:48]);
      ca       <= table_sin(16'(s_tdata[63:48] + 16'd16384));
      sb       <= table_sin(s_tdata[79:64]);
      cb       <= table_sin(16'(s_tdata[79:64] + 16'd16384));
      sc       <= table_sin(s_tdata[95:80]);
      cc       <= table_sin(16'(s_tdata[95:80] + 16'd16384));
      glyph_in <= s_tdata[103:96];
      idx      <= s_tdata[116:104];
    end
  end

  // shared multiplier
  logic signed [15:0] casb, sasb;
  logic signed [16:0] m00, m01, m02, m10, m11, m12, m21, m22;
  logic signed [33:0] acc;
  logic signed [18:0] xr, yr;
  logic signed [19:0] z;
  logic [27:0]        fi;
  logic [35:0]        fia;
  logic signed [31:0] col, row;
  logic signed [39:0] cell_lin;
  logic [15:0]        inv;

  logic signed [36:0] ma;
  logic signed [24:0] mb;
  logic signed [63:0] prod;
  logic signed [63:0] p64, q14, dot, zsum;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_CASB: begin ma = 37'(ca);   mb = 25'(sb); end
      OP_SASB: begin ma = 37'(sa);   mb = 25'(sb); end
      OP_M00:  begin ma = 37'(ca);   mb = 25'(cb); end
      OP_M01A: begin ma = 37'(casb); mb = 25'(sc); end
      OP_M01B: begin ma = 37'(sa);   mb = 25'(cc); end
      OP_M02A: begin ma = 37'(sa);   mb = 25'(sc); end
      OP_M02B: begin ma = 37'(casb); mb = 25'(cc); end
      OP_M10:  begin ma = 37'(sa);   mb = 25'(cb); end
      OP_M11A: begin ma = 37'(ca);   mb = 25'(cc); end
      OP_M11B: begin ma = 37'(sasb); mb = 25'(sc); end
      OP_M12A: begin ma = 37'(sasb); mb = 25'(cc); end
      OP_M12B: begin ma = 37'(ca);   mb = 25'(sc); end
      OP_M21:  begin ma = 37'(cb);   mb = 25'(sc); end
      OP_M22:  begin ma = 37'(cb);   mb = 25'(cc); end
      OP_X0:   begin ma = 37'(px);   mb = 25'(m00); end
      OP_X1:   begin ma = 37'(py);   mb = 25'(m01); end
      OP_X2:   begin ma = 37'(pz);   mb = 25'(m02); end
      OP_Y0:   begin ma = 37'(px);   mb = 25'(m10); end
      OP_Y1:   begin ma = 37'(py);   mb = 25'(m11); end
      OP_Y2:   begin ma = 37'(pz);   mb = 25'(m12); end
      OP_Z0:   begin ma = 37'(px);   mb = -25'(sb); end
      OP_Z1:   begin ma = 37'(py);   mb = 25'(m21); end
      OP_Z2:   begin ma = 37'(pz);   mb = 25'(m22); end
      OP_FI:   begin ma = $signed({25'd0, focal}); mb = $signed({9'd0, inv}); end
      OP_FIAX: begin ma = $signed({9'd0, fi});     mb = $signed({17'd0, asp_x}); end
      OP_COL:  begin ma = $signed({1'b0, fia});    mb = 25'(xr); end
      OP_FIAY: begin ma = $signed({9'd0, fi});     mb = $signed({17'd0, asp_y}); end
      OP_ROW:  begin ma = $signed({1'b0, fia});    mb = 25'(yr); end
      OP_CELL: begin ma = 37'(row);                mb = $signed({17'd0, w_eff}); end
      default: ;
    endcase
  end

  assign prod = ma * mb;
  assign p64  = prod;
  assign q14  = rnd14(p64);
  assign dot  = rnd14(64'(acc) + p64);
  assign zsum = dot + $signed({46'd0, view_d, 8'd0});

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CASB: casb <= 16'(q14);
      OP_SASB: sasb <= 16'(q14);
      OP_M00:  m00  <= 17'(q14);
      OP_M01A: m01  <= 17'(q14);
      OP_M01B: m01  <= 17'(m01 - 17'(q14));
      OP_M02A: m02  <= 17'(q14);
      OP_M02B: m02  <= 17'(m02 + 17'(q14));
      OP_M10:  m10  <= 17'(q14);
      OP_M11A: m11  <= 17'(q14);
      OP_M11B: m11  <= 17'(m11 + 17'(q14));
      OP_M12A: m12  <= 17'(q14);
      OP_M12B: m12  <= 17'(m12 - 17'(q14));
      OP_M21:  m21  <= 17'(q14);
      OP_M22:  m22  <= 17'(q14);
      OP_X0, OP_Y0, OP_Z0: acc <= 34'(p64);
      OP_X1, OP_Y1, OP_Z1: acc <= 34'(64'(acc) + p64);
      OP_X2:   xr   <= 19'(dot);
      OP_Y2:   yr   <= 19'(dot);
      OP_Z2:   z    <= 20'(zsum);
      OP_FI:   fi   <= 28'(p64);
      OP_FIAX, OP_FIAY: fia <= 36'(p64);
      OP_COL:  col  <= 32'(rnd32(p64 + $signed({25'd0, w_eff, 31'd0})));
      OP_ROW:  row  <= 32'(rnd32(p64 + $signed({26'd0, h_eff, 31'd0})));
      OP_CELL: cell_lin <= 40'(64'(col) + p64);
      default: ;
    endcase
  end

  // restoring divider: (2^24 + z/2) / z, one quotient bit per step
  logic [24:0] num;
  logic [19:0] rem;
  logic [19:0] trial;
  logic [24:0] quo;
  logic [4:0]  div_cnt;
  logic        q_bit;

  assign trial = {rem[18:0], num[24]};
  assign q_bit = trial >= {1'b0, z[18:0]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num     <= 25'(25'd16777216 + {6'd0, z[19:1]});
      rem     <= '0;
      quo     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      num     <= {num[23:0], 1'b0};
      rem     <= q_bit ? 20'(trial - {1'b0, z[18:0]}) : trial;
      quo     <= {quo[23:0], q_bit};
      div_cnt <= 5'(div_cnt + 5'd1);
    end
  end

  assign inv = (quo > 25'd65535) ? 16'hFFFF : quo[15:0];

  // glyph and depth stores
  logic [7:0]    glyph_mem [CELL_COUNT];
  logic [15:0]   depth_mem [CELL_COUNT];
  logic [AW-1:0] sweep_addr;
  logic [AW-1:0] mem_addr;
  logic [7:0]    gq;
  logic [15:0]   dq;
  logic          win;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_glyph;
  logic [15:0]   wr_depth;

  always_ff @(posedge clk) begin
    if (rst)            sweep_addr <= '0;
    else if (cmd.sweep) sweep_addr <= AW'(sweep_addr + 1'b1);
  end

  assign mem_addr = (func == FUNC_PLOT) ? cell_lin[AW-1:0] : AW'(idx);
  assign win      = inv > dq;

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = mem_addr;
    wr_glyph = glyph_in;
    wr_depth = inv;
    if (cmd.sweep) begin
      wr_en    = 1'b1;
      wr_addr  = sweep_addr;
      wr_glyph = 8'd32;
      wr_depth = 16'd0;
    end else if (cmd.out_load && cmd.kind == KIND_CELL && func == FUNC_CLEAR) begin
      wr_en    = 1'b1;
      wr_glyph = bg_glyph;
      wr_depth = 16'd0;
    end else if (cmd.out_load && cmd.kind == KIND_PLOT && win) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      glyph_mem[wr_addr] <= wr_glyph;
      depth_mem[wr_addr] <= wr_depth;
    end
    if (cmd.mem_rd) begin
      gq <= glyph_mem[mem_addr];
      dq <= depth_mem[mem_addr];
    end
  end

  // result register
  logic        out_valid;
  logic        out_free;
  logic [12:0] out_cell;
  logic [7:0]  out_glyph;
  logic [15:0] out_depth;
  logic        out_acc;
  logic        out_drop;

  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (m_tready)     out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cell  <= '0;
      out_glyph <= '0;
      out_depth <= '0;
      out_acc   <= 1'b0;
      out_drop  <= 1'b0;
      case (cmd.kind)
        KIND_DROP: out_drop <= 1'b1;
        KIND_BADIDX: begin
          out_cell <= idx;
          out_drop <= 1'b1;
        end
        KIND_PLOT: begin
          out_cell <= cell_lin[12:0];
          if (win) begin
            out_glyph <= glyph_in;
            out_depth <= inv;
            out_acc   <= 1'b1;
          end else begin
            out_glyph <= gq;
            out_depth <= dq;
          end
        end
        KIND_CELL: begin
          out_cell <= idx;
          if (func == FUNC_CLEAR) begin
            out_glyph <= bg_glyph;
          end else begin
            out_glyph <= gq;
            out_depth <= dq;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, out_depth, out_glyph, out_cell};
  assign m_tuser  = {out_drop, out_acc};

  // status
  assign sts.func       = func;
  assign sts.idx_bad    = 32'(idx) >= 32'(CELL_COUNT);
  assign sts.z_low      = z[19] || (z[18:0] < 19'd256);
  assign sts.div_done   = div_cnt == 5'(DIV_STEPS - 1);
  assign sts.cell_bad   = cell_lin[39] || (cell_lin[38:0] >= 39'(wh));
  assign sts.out_free   = out_free;
  assign sts.sweep_last = sweep_addr == AW'(CELL_COUNT - 1);

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result loaded over a pending result");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");
  a_win_depth: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.kind == KIND_PLOT && win) |-> inv != 16'd0)
    else $error("winning point with zero depth");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> div_cnt == 5'd0)
    else $error("divider step count not cleared");
`endif

endmodule

### src/rotate_project_depth_plot.sv
// ----------------------------------------------------------------------------
// rotate_project_depth_plot
// Rotates, projects and depth-tests one 3D point per request into a glyph grid.
// ----------------------------------------------------------------------------
// Input requests arrive on s_t*: tuser carries the function (plot, clear,
// read), tdata the point, three angles, glyph and cell index. One result per
// plot, clear or read request leaves on m_t*; function code 3 gives none.
// The block works on one request at a time. From acceptance to the result
// register a plot runs 23 steps of the single shared multiplier for the
// rotation, 25 steps of the bit-serial 1/z divider and 6 more multiplier
// steps for the projection and cell address, plus store access. A clear or
// read with a valid cell index reads its store cell before the result; a
// dropped plot ends after the depth check or the grid check.
// After reset the block sweeps the glyph and depth stores, one cell a cycle,
// through all SCREEN_COLS*SCREEN_ROWS cells (8192 by default) with s_tready
// low; configuration writes are taken during the sweep.
// The result sits in an output register: the next request is accepted while
// it waits, and a stalled receiver holds the following result in its final
// state until the register frees up.
// ----------------------------------------------------------------------------
module rotate_project_depth_plot #(
  parameter int SCREEN_COLS = rpdp_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = rpdp_pkg::SCREEN_ROWS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [11:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // point_x, point_y, point_z, angle_a, angle_b, angle_c, glyph, cell_index
  input  logic [119:0] s_tdata,
  // func
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // cell_out, glyph_out, depth_out
  output logic [39:0]  m_tdata,
  // accepted, dropped
  output logic [1:0]   m_tuser
);
  import rpdp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rpdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  rpdp_datapath #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
